/* rtl/dsve_pkg.sv */
// Shared types and the microprogram of the DSA sign / verify engine.
// Used by dsve_ctrl, dsve_datapath and dsa_sign_verify_engine_core; no dependencies.
package dsve_pkg;

    typedef logic [5:0] t_pc;

    typedef enum logic [3:0] {
        OP_BR, OP_CALL, OP_RET,
        OP_MOV, OP_DEC, OP_SHR, OP_ONE, OP_ADDM, OP_SUBM, OP_DIV, OP_MUL, OP_FIN
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS, C_MODE0, C_MODE1, C_MODE3, C_RANGE_BAD, C_EXP_ZERO, C_EXP_EVEN, C_R1_ZERO
    } t_cond;

    typedef enum logic [4:0] {
        SEL_ZERO, SEL_P, SEL_Q, SEL_H, SEL_X, SEL_MSG, SEL_K, SEL_Y, SEL_SR, SEL_SS,
        SEL_G, SEL_ACC, SEL_BASE, SEL_EXP, SEL_R0, SEL_R1, SEL_C0, SEL_C1, SEL_QT,
        SEL_EX, SEL_T0, SEL_T1, SEL_RS
    } t_sel;

    localparam logic [1:0] MODE_PUBKEY = 2'd0;
    localparam logic [1:0] MODE_SIGN   = 2'd1;
    localparam logic [1:0] MODE_VERIFY = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] CFG_PRIME_P = 2'd0;
    localparam logic [1:0] CFG_PRIME_Q = 2'd1;
    localparam logic [1:0] CFG_BASE_H  = 2'd2;

    localparam t_pc PC_M0       = 6'd23;
    localparam t_pc PC_M1       = 6'd27;
    localparam t_pc PC_FIN      = 6'd37;
    localparam t_pc PC_POW      = 6'd38;
    localparam t_pc PC_POW_LOOP = 6'd39;
    localparam t_pc PC_POW_SQR  = 6'd42;
    localparam t_pc PC_POW_END  = 6'd45;
    localparam t_pc PC_INV      = 6'd46;
    localparam t_pc PC_INV_LOOP = 6'd49;
    localparam t_pc PC_INV_END  = 6'd58;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_sel  a;
        t_sel  b;
        t_sel  m;
        t_sel  d;
        t_sel  d2;
        t_pc   tgt;
    } t_uinst;

    typedef struct packed {
        logic valid;
        t_op  op;
        t_sel a;
        t_sel b;
        t_sel m;
        t_sel d;
        t_sel d2;
    } t_cmd;

    typedef struct packed {
        logic       done;
        logic       exp_zero;
        logic       exp_even;
        logic       r1_zero;
        logic       range_bad;
        logic [1:0] mode;
    } t_stat;

    function automatic t_uinst mk(t_op op, t_cond c, t_sel a, t_sel b, t_sel m,
                                  t_sel d, t_sel d2, t_pc t);
        t_uinst u;
        u = '{op: op, cond: c, a: a, b: b, m: m, d: d, d2: d2, tgt: t};
        return u;
    endfunction

    // Generator first, then one routine per mode; POW and INV are subroutines.
    function automatic t_uinst ucode(t_pc pc);
        t_uinst u;
        case (pc)
            6'd0:  u = mk(OP_BR,   C_MODE3,     SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_FIN);
            6'd1:  u = mk(OP_DEC,  C_ALWAYS,    SEL_P,    SEL_ZERO, SEL_ZERO, SEL_EX,   SEL_ZERO, '0);
            6'd2:  u = mk(OP_DIV,  C_ALWAYS,    SEL_EX,   SEL_Q,    SEL_ZERO, SEL_EXP,  SEL_ZERO, '0);
            6'd3:  u = mk(OP_MOV,  C_ALWAYS,    SEL_H,    SEL_ZERO, SEL_ZERO, SEL_BASE, SEL_ZERO, '0);
            6'd4:  u = mk(OP_CALL, C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_POW);
            6'd5:  u = mk(OP_MOV,  C_ALWAYS,    SEL_ACC,  SEL_ZERO, SEL_ZERO, SEL_G,    SEL_ZERO, '0);
            6'd6:  u = mk(OP_BR,   C_MODE0,     SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_M0);
            6'd7:  u = mk(OP_BR,   C_MODE1,     SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_M1);
            6'd8:  u = mk(OP_BR,   C_RANGE_BAD, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_FIN);
            6'd9:  u = mk(OP_DIV,  C_ALWAYS,    SEL_SS,   SEL_Q,    SEL_ZERO, SEL_ZERO, SEL_R0,   '0);
            6'd10: u = mk(OP_CALL, C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_INV);
            6'd11: u = mk(OP_MUL,  C_ALWAYS,    SEL_MSG,  SEL_C0,   SEL_Q,    SEL_T0,   SEL_ZERO, '0);
            6'd12: u = mk(OP_MUL,  C_ALWAYS,    SEL_SR,   SEL_C0,   SEL_Q,    SEL_T1,   SEL_ZERO, '0);
            6'd13: u = mk(OP_MOV,  C_ALWAYS,    SEL_T0,   SEL_ZERO, SEL_ZERO, SEL_EXP,  SEL_ZERO, '0);
            6'd14: u = mk(OP_MOV,  C_ALWAYS,    SEL_G,    SEL_ZERO, SEL_ZERO, SEL_BASE, SEL_ZERO, '0);
            6'd15: u = mk(OP_CALL, C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_POW);
            6'd16: u = mk(OP_MOV,  C_ALWAYS,    SEL_ACC,  SEL_ZERO, SEL_ZERO, SEL_RS,   SEL_ZERO, '0);
            6'd17: u = mk(OP_MOV,  C_ALWAYS,    SEL_T1,   SEL_ZERO, SEL_ZERO, SEL_EXP,  SEL_ZERO, '0);
            6'd18: u = mk(OP_MOV,  C_ALWAYS,    SEL_Y,    SEL_ZERO, SEL_ZERO, SEL_BASE, SEL_ZERO, '0);
            6'd19: u = mk(OP_CALL, C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_POW);
            6'd20: u = mk(OP_MUL,  C_ALWAYS,    SEL_RS,   SEL_ACC,  SEL_P,    SEL_T0,   SEL_ZERO, '0);
            6'd21: u = mk(OP_DIV,  C_ALWAYS,    SEL_T0,   SEL_Q,    SEL_ZERO, SEL_ZERO, SEL_T1,   '0);
            6'd22: u = mk(OP_BR,   C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_FIN);
            6'd23: u = mk(OP_MOV,  C_ALWAYS,    SEL_X,    SEL_ZERO, SEL_ZERO, SEL_EXP,  SEL_ZERO, '0);
            6'd24: u = mk(OP_MOV,  C_ALWAYS,    SEL_G,    SEL_ZERO, SEL_ZERO, SEL_BASE, SEL_ZERO, '0);
            6'd25: u = mk(OP_CALL, C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_POW);
            6'd26: u = mk(OP_BR,   C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_FIN);
            6'd27: u = mk(OP_MOV,  C_ALWAYS,    SEL_K,    SEL_ZERO, SEL_ZERO, SEL_EXP,  SEL_ZERO, '0);
            6'd28: u = mk(OP_MOV,  C_ALWAYS,    SEL_G,    SEL_ZERO, SEL_ZERO, SEL_BASE, SEL_ZERO, '0);
            6'd29: u = mk(OP_CALL, C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_POW);
            6'd30: u = mk(OP_DIV,  C_ALWAYS,    SEL_ACC,  SEL_Q,    SEL_ZERO, SEL_ZERO, SEL_RS,   '0);
            6'd31: u = mk(OP_DIV,  C_ALWAYS,    SEL_MSG,  SEL_Q,    SEL_ZERO, SEL_ZERO, SEL_T1,   '0);
            6'd32: u = mk(OP_MUL,  C_ALWAYS,    SEL_X,    SEL_RS,   SEL_Q,    SEL_T0,   SEL_ZERO, '0);
            6'd33: u = mk(OP_ADDM, C_ALWAYS,    SEL_T1,   SEL_T0,   SEL_Q,    SEL_T0,   SEL_ZERO, '0);
            6'd34: u = mk(OP_DIV,  C_ALWAYS,    SEL_K,    SEL_Q,    SEL_ZERO, SEL_ZERO, SEL_R0,   '0);
            6'd35: u = mk(OP_CALL, C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_INV);
            6'd36: u = mk(OP_MUL,  C_ALWAYS,    SEL_C0,   SEL_T0,   SEL_Q,    SEL_T1,   SEL_ZERO, '0);
            6'd37: u = mk(OP_FIN,  C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, '0);
            6'd38: u = mk(OP_ONE,  C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_P,    SEL_ACC,  SEL_ZERO, '0);
            6'd39: u = mk(OP_BR,   C_EXP_ZERO,  SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_POW_END);
            6'd40: u = mk(OP_BR,   C_EXP_EVEN,  SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_POW_SQR);
            6'd41: u = mk(OP_MUL,  C_ALWAYS,    SEL_ACC,  SEL_BASE, SEL_P,    SEL_ACC,  SEL_ZERO, '0);
            6'd42: u = mk(OP_MUL,  C_ALWAYS,    SEL_BASE, SEL_BASE, SEL_P,    SEL_BASE, SEL_ZERO, '0);
            6'd43: u = mk(OP_SHR,  C_ALWAYS,    SEL_EXP,  SEL_ZERO, SEL_ZERO, SEL_EXP,  SEL_ZERO, '0);
            6'd44: u = mk(OP_BR,   C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_POW_LOOP);
            6'd45: u = mk(OP_RET,  C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, '0);
            6'd46: u = mk(OP_MOV,  C_ALWAYS,    SEL_Q,    SEL_ZERO, SEL_ZERO, SEL_R1,   SEL_ZERO, '0);
            6'd47: u = mk(OP_ONE,  C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_Q,    SEL_C0,   SEL_ZERO, '0);
            6'd48: u = mk(OP_MOV,  C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_C1,   SEL_ZERO, '0);
            6'd49: u = mk(OP_BR,   C_R1_ZERO,   SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_INV_END);
            6'd50: u = mk(OP_DIV,  C_ALWAYS,    SEL_R0,   SEL_R1,   SEL_ZERO, SEL_QT,   SEL_EX,   '0);
            6'd51: u = mk(OP_MOV,  C_ALWAYS,    SEL_R1,   SEL_ZERO, SEL_ZERO, SEL_R0,   SEL_ZERO, '0);
            6'd52: u = mk(OP_MOV,  C_ALWAYS,    SEL_EX,   SEL_ZERO, SEL_ZERO, SEL_R1,   SEL_ZERO, '0);
            6'd53: u = mk(OP_MUL,  C_ALWAYS,    SEL_QT,   SEL_C1,   SEL_Q,    SEL_EX,   SEL_ZERO, '0);
            6'd54: u = mk(OP_SUBM, C_ALWAYS,    SEL_C0,   SEL_EX,   SEL_Q,    SEL_EX,   SEL_ZERO, '0);
            6'd55: u = mk(OP_MOV,  C_ALWAYS,    SEL_C1,   SEL_ZERO, SEL_ZERO, SEL_C0,   SEL_ZERO, '0);
            6'd56: u = mk(OP_MOV,  C_ALWAYS,    SEL_EX,   SEL_ZERO, SEL_ZERO, SEL_C1,   SEL_ZERO, '0);
            6'd57: u = mk(OP_BR,   C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, PC_INV_LOOP);
            6'd58: u = mk(OP_RET,  C_ALWAYS,    SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, '0);
            default: u = mk(OP_FIN, C_ALWAYS,   SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, SEL_ZERO, '0);
        endcase
        return u;
    endfunction

endpackage

/* rtl/dsa_sign_verify_engine_core.sv */
// DSA sign / verify engine: top level joining the sequencer and the datapath.
// Depends on dsve_pkg, dsve_ctrl and dsve_datapath.
//
// A transaction is accepted at a rising edge where start is high and busy is low; the
// mode and operand ports are sampled then. busy stays high until the result has been
// shown. Each transaction gives one result, on o_value_a, o_value_b and o_valid_res,
// held for exactly one cycle while o_valid is high; the receiver cannot stall it.
// Configuration (p, q, h) is written through i_cfg_we, i_cfg_idx and i_cfg_data while
// busy is low, and is sampled at acceptance.
// The run time is set by the shared divider and modular multiplier. Each command step is
// fetched and then waits for the datapath's done. A division restores its quotient bit by
// bit; a modular multiply reduces both operands by division and then runs a double-and-add
// pass. An exponentiation does one squaring per exponent bit, one multiply per set bit and
// the loop steps. A transaction runs one for (p-1)/q and one per exponent of its mode, plus
// the extended Euclid iterations of a modular inverse in the sign and verify modes.
// Transactions do not overlap. Reset restores p = 67, q = 11, h = 3 and returns to idle.
module dsa_sign_verify_engine_core #(
    parameter int WORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_private_key,
    input  logic [31:0] i_message,
    input  logic [31:0] i_nonce,
    input  logic [31:0] i_public_key,
    input  logic [31:0] i_sig_r,
    input  logic [31:0] i_sig_s,
    output logic        o_valid,
    output logic [31:0] o_value_a,
    output logic [31:0] o_value_b,
    output logic        o_valid_res
);

    dsve_pkg::t_cmd  w_cmd;
    dsve_pkg::t_stat w_stat;
    logic            w_busy;
    logic            w_accept;

    assign w_accept = start && !w_busy;
    assign busy     = w_busy;

    dsve_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    dsve_datapath #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_load        (w_accept),
        .i_mode        (i_mode),
        .i_private_key (i_private_key),
        .i_message     (i_message),
        .i_nonce       (i_nonce),
        .i_public_key  (i_public_key),
        .i_sig_r       (i_sig_r),
        .i_sig_s       (i_sig_s),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_value_a     (o_value_a),
        .o_value_b     (o_value_b),
        .o_valid_res   (o_valid_res)
    );

    a_result_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown outside a transaction");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid))
        else $error("engine did not return to idle after its result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted transaction did not start");

endmodule

/* rtl/dsve_ctrl.sv */
// Microprogram sequencer of the DSA engine: fetches dsve_pkg::ucode and issues commands.
// Depends on dsve_pkg.
module dsve_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  dsve_pkg::t_stat i_stat,
    output dsve_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_WAIT} t_state;

    t_state           r_state;
    dsve_pkg::t_pc    r_pc;
    dsve_pkg::t_pc    r_ret;
    dsve_pkg::t_cmd   r_cmd;
    logic             r_busy;
    dsve_pkg::t_uinst w_ui;
    logic             w_cond;

    assign w_ui = dsve_pkg::ucode(r_pc);

    always_comb begin
        unique case (w_ui.cond)
            dsve_pkg::C_ALWAYS:    w_cond = 1'b1;
            dsve_pkg::C_MODE0:     w_cond = (i_stat.mode == dsve_pkg::MODE_PUBKEY);
            dsve_pkg::C_MODE1:     w_cond = (i_stat.mode == dsve_pkg::MODE_SIGN);
            dsve_pkg::C_MODE3:     w_cond = (i_stat.mode == dsve_pkg::MODE_NONE);
            dsve_pkg::C_RANGE_BAD: w_cond = i_stat.range_bad;
            dsve_pkg::C_EXP_ZERO:  w_cond = i_stat.exp_zero;
            dsve_pkg::C_EXP_EVEN:  w_cond = i_stat.exp_even;
            dsve_pkg::C_R1_ZERO:   w_cond = i_stat.r1_zero;
            default:               w_cond = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_ret   <= '0;
            r_cmd   <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_cmd.valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_pc    <= '0;
                        r_busy  <= 1'b1;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    unique case (w_ui.op)
                        dsve_pkg::OP_BR: begin
                            r_pc <= w_cond ? w_ui.tgt : r_pc + 1'b1;
                        end
                        dsve_pkg::OP_CALL: begin
                            r_ret <= r_pc + 1'b1;
                            r_pc  <= w_ui.tgt;
                        end
                        dsve_pkg::OP_RET: begin
                            r_pc <= r_ret;
                        end
                        default: begin
                            r_cmd   <= '{valid: 1'b1, op: w_ui.op, a: w_ui.a, b: w_ui.b,
                                         m: w_ui.m, d: w_ui.d, d2: w_ui.d2};
                            r_state <= S_WAIT;
                        end
                    endcase
                end
                S_WAIT: begin
                    if (i_stat.done) begin
                        if (w_ui.op == dsve_pkg::OP_FIN) begin
                            r_busy  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_pc    <= r_pc + 1'b1;
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd  = r_cmd;
    assign o_busy = r_busy;

endmodule

/* rtl/dsve_datapath.sv */
// Datapath of the DSA engine: configuration, working registers, shared divider and
// modular multiplier, result registers. Depends on dsve_pkg.
module dsve_datapath #(
    parameter int WORD_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    input  logic            i_load,
    input  logic [1:0]      i_mode,
    input  logic [31:0]     i_private_key,
    input  logic [31:0]     i_message,
    input  logic [31:0]     i_nonce,
    input  logic [31:0]     i_public_key,
    input  logic [31:0]     i_sig_r,
    input  logic [31:0]     i_sig_s,
    input  dsve_pkg::t_cmd  i_cmd,
    output dsve_pkg::t_stat o_stat,
    output logic            o_valid,
    output logic [31:0]     o_value_a,
    output logic [31:0]     o_value_b,
    output logic            o_valid_res
);

    localparam int W  = WORD_WIDTH;
    localparam int CW = $clog2(WORD_WIDTH);

    typedef enum logic [2:0] {PH_IDLE, PH_DIV, PH_MRA, PH_MRB, PH_MUL} t_ph;

    logic [31:0] r_cfg_p, r_cfg_q, r_cfg_h;
    logic [1:0]  r_mode;
    logic [W-1:0] r_p, r_q, r_h, r_x, r_msg, r_k, r_y, r_sr, r_ss;
    logic [W-1:0] r_g, r_acc, r_base, r_exp, r_r0, r_r1, r_c0, r_c1, r_qt, r_ex;
    logic [W-1:0] r_t0, r_t1, r_rs;
    t_ph          r_ph;
    logic [CW-1:0] r_cnt;
    logic [W-1:0] r_dq, r_rem, r_dv, r_ma, r_mb, r_macc;
    dsve_pkg::t_sel r_dst, r_dst2;
    logic         r_done, r_vld, r_ok;
    logic [31:0]  r_va, r_vb;

    logic [W-1:0] w_a, w_b, w_m;
    logic [W:0]   w_rem2;
    logic         w_ge, w_last, w_range_bad;
    logic [W-1:0] w_rem_nx, w_dq_nx, w_quo_f, w_rem_f, w_mul1, w_mul_nx;
    logic         w1_en, w2_en;
    dsve_pkg::t_sel w1_sel;
    logic [W-1:0] w1_val, w2_val;

    function automatic logic [W-1:0] addm(logic [W-1:0] a, logic [W-1:0] b,
                                          logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : W'(s);
    endfunction

    function automatic logic [W-1:0] subm(logic [W-1:0] a, logic [W-1:0] b,
                                          logic [W-1:0] m);
        return (a >= b) ? a - b : a + (m - b);
    endfunction

    function automatic logic [W-1:0] rd(dsve_pkg::t_sel s, logic [W-1:0] p,
        logic [W-1:0] q, logic [W-1:0] h, logic [W-1:0] x, logic [W-1:0] msg,
        logic [W-1:0] k, logic [W-1:0] y, logic [W-1:0] sr, logic [W-1:0] ss,
        logic [W-1:0] g, logic [W-1:0] acc, logic [W-1:0] base, logic [W-1:0] ex_p,
        logic [W-1:0] r0, logic [W-1:0] r1, logic [W-1:0] c0, logic [W-1:0] c1,
        logic [W-1:0] qt, logic [W-1:0] ex, logic [W-1:0] t0, logic [W-1:0] t1,
        logic [W-1:0] rs);
        logic [W-1:0] v;
        case (s)
            dsve_pkg::SEL_P:    v = p;
            dsve_pkg::SEL_Q:    v = q;
            dsve_pkg::SEL_H:    v = h;
            dsve_pkg::SEL_X:    v = x;
            dsve_pkg::SEL_MSG:  v = msg;
            dsve_pkg::SEL_K:    v = k;
            dsve_pkg::SEL_Y:    v = y;
            dsve_pkg::SEL_SR:   v = sr;
            dsve_pkg::SEL_SS:   v = ss;
            dsve_pkg::SEL_G:    v = g;
            dsve_pkg::SEL_ACC:  v = acc;
            dsve_pkg::SEL_BASE: v = base;
            dsve_pkg::SEL_EXP:  v = ex_p;
            dsve_pkg::SEL_R0:   v = r0;
            dsve_pkg::SEL_R1:   v = r1;
            dsve_pkg::SEL_C0:   v = c0;
            dsve_pkg::SEL_C1:   v = c1;
            dsve_pkg::SEL_QT:   v = qt;
            dsve_pkg::SEL_EX:   v = ex;
            dsve_pkg::SEL_T0:   v = t0;
            dsve_pkg::SEL_T1:   v = t1;
            dsve_pkg::SEL_RS:   v = rs;
            default:            v = '0;
        endcase
        return v;
    endfunction

    assign w_a = rd(i_cmd.a, r_p, r_q, r_h, r_x, r_msg, r_k, r_y, r_sr, r_ss, r_g, r_acc,
                    r_base, r_exp, r_r0, r_r1, r_c0, r_c1, r_qt, r_ex, r_t0, r_t1, r_rs);
    assign w_b = rd(i_cmd.b, r_p, r_q, r_h, r_x, r_msg, r_k, r_y, r_sr, r_ss, r_g, r_acc,
                    r_base, r_exp, r_r0, r_r1, r_c0, r_c1, r_qt, r_ex, r_t0, r_t1, r_rs);
    assign w_m = rd(i_cmd.m, r_p, r_q, r_h, r_x, r_msg, r_k, r_y, r_sr, r_ss, r_g, r_acc,
                    r_base, r_exp, r_r0, r_r1, r_c0, r_c1, r_qt, r_ex, r_t0, r_t1, r_rs);

    // One restoring division step per cycle; a zero divisor gives zero quotient and remainder.
    assign w_rem2   = {r_rem, r_dq[W-1]};
    assign w_ge     = (w_rem2 >= {1'b0, r_dv});
    assign w_rem_nx = w_ge ? W'(w_rem2 - {1'b0, r_dv}) : W'(w_rem2);
    assign w_dq_nx  = {r_dq[W-2:0], w_ge};
    assign w_quo_f  = (r_dv == '0) ? '0 : w_dq_nx;
    assign w_rem_f  = (r_dv == '0) ? '0 : w_rem_nx;
    assign w_last   = (r_cnt == '0);

    // Left-to-right double-and-add multiplication modulo r_dv.
    assign w_mul1   = addm(r_macc, r_macc, r_dv);
    assign w_mul_nx = r_mb[W-1] ? addm(w_mul1, r_ma, r_dv) : w_mul1;

    assign w_range_bad = !((r_sr != '0) && (r_sr < r_q) && (r_ss != '0) && (r_ss < r_q));

    always_comb begin
        w1_en  = 1'b0;
        w1_sel = r_dst;
        w1_val = '0;
        w2_en  = 1'b0;
        w2_val = w_rem_f;
        if (i_cmd.valid) begin
            w1_sel = i_cmd.d;
            case (i_cmd.op)
                dsve_pkg::OP_MOV:  begin w1_en = 1'b1; w1_val = w_a; end
                dsve_pkg::OP_DEC:  begin w1_en = 1'b1; w1_val = w_a - 1'b1; end
                dsve_pkg::OP_SHR:  begin w1_en = 1'b1; w1_val = w_a >> 1; end
                dsve_pkg::OP_ONE:  begin w1_en = 1'b1; w1_val = W'(w_m > W'(1)); end
                dsve_pkg::OP_ADDM: begin w1_en = 1'b1; w1_val = addm(w_a, w_b, w_m); end
                dsve_pkg::OP_SUBM: begin w1_en = 1'b1; w1_val = subm(w_a, w_b, w_m); end
                default:           w1_en = 1'b0;
            endcase
        end else if (r_ph == PH_DIV && w_last) begin
            w1_en  = 1'b1;
            w1_val = w_quo_f;
            w2_en  = 1'b1;
        end else if (r_ph == PH_MUL && w_last) begin
            w1_en  = 1'b1;
            w1_val = w_mul_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_p <= 32'd67;
            r_cfg_q <= 32'd11;
            r_cfg_h <= 32'd3;
            r_ph    <= PH_IDLE;
            r_done  <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_vld  <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dsve_pkg::CFG_PRIME_P: r_cfg_p <= i_cfg_data;
                    dsve_pkg::CFG_PRIME_Q: r_cfg_q <= i_cfg_data;
                    dsve_pkg::CFG_BASE_H:  r_cfg_h <= i_cfg_data;
                    default:               ;
                endcase
            end
            if (i_load) begin
                r_mode <= i_mode;
                r_p    <= W'(r_cfg_p);
                r_q    <= W'(r_cfg_q);
                r_h    <= W'(r_cfg_h);
                r_x    <= W'(i_private_key);
                r_msg  <= W'(i_message);
                r_k    <= W'(i_nonce);
                r_y    <= W'(i_public_key);
                r_sr   <= W'(i_sig_r);
                r_ss   <= W'(i_sig_s);
            end
            if (i_cmd.valid) begin
                r_dst  <= i_cmd.d;
                r_dst2 <= i_cmd.d2;
                r_dq   <= w_a;
                r_rem  <= '0;
                r_cnt  <= CW'(W - 1);
                case (i_cmd.op)
                    dsve_pkg::OP_DIV: begin
                        r_dv <= w_b;
                        r_ph <= PH_DIV;
                    end
                    dsve_pkg::OP_MUL: begin
                        r_dv <= w_m;
                        r_mb <= w_b;
                        r_ph <= PH_MRA;
                    end
                    dsve_pkg::OP_FIN: begin
                        r_done <= 1'b1;
                        r_vld  <= 1'b1;
                        r_va   <= '0;
                        r_vb   <= '0;
                        r_ok   <= 1'b0;
                        case (r_mode)
                            dsve_pkg::MODE_PUBKEY: r_va <= 32'(r_acc);
                            dsve_pkg::MODE_SIGN: begin
                                r_va <= 32'(r_rs);
                                r_vb <= 32'(r_t1);
                            end
                            dsve_pkg::MODE_VERIFY: r_ok <= !w_range_bad && (r_t1 == r_sr);
                            default:               r_ok <= 1'b0;
                        endcase
                    end
                    default: r_done <= 1'b1;
                endcase
            end else begin
                case (r_ph)
                    PH_DIV, PH_MRA, PH_MRB: begin
                        r_dq  <= w_dq_nx;
                        r_rem <= w_rem_nx;
                        r_cnt <= r_cnt - 1'b1;
                        if (w_last) begin
                            r_cnt <= CW'(W - 1);
                            r_rem <= '0;
                            case (r_ph)
                                PH_MRA: begin
                                    r_ma <= w_rem_f;
                                    r_dq <= r_mb;
                                    r_ph <= PH_MRB;
                                end
                                PH_MRB: begin
                                    r_mb   <= w_rem_f;
                                    r_macc <= '0;
                                    r_ph   <= PH_MUL;
                                end
                                default: begin
                                    r_done <= 1'b1;
                                    r_ph   <= PH_IDLE;
                                end
                            endcase
                        end
                    end
                    PH_MUL: begin
                        r_macc <= w_mul_nx;
                        r_mb   <= {r_mb[W-2:0], 1'b0};
                        r_cnt  <= r_cnt - 1'b1;
                        if (w_last) begin
                            r_done <= 1'b1;
                            r_ph   <= PH_IDLE;
                        end
                    end
                    default: r_ph <= PH_IDLE;
                endcase
            end
            if (w2_en) begin
                case (r_dst2)
                    dsve_pkg::SEL_G:    r_g    <= w2_val;
                    dsve_pkg::SEL_ACC:  r_acc  <= w2_val;
                    dsve_pkg::SEL_BASE: r_base <= w2_val;
                    dsve_pkg::SEL_EXP:  r_exp  <= w2_val;
                    dsve_pkg::SEL_R0:   r_r0   <= w2_val;
                    dsve_pkg::SEL_R1:   r_r1   <= w2_val;
                    dsve_pkg::SEL_C0:   r_c0   <= w2_val;
                    dsve_pkg::SEL_C1:   r_c1   <= w2_val;
                    dsve_pkg::SEL_QT:   r_qt   <= w2_val;
                    dsve_pkg::SEL_EX:   r_ex   <= w2_val;
                    dsve_pkg::SEL_T0:   r_t0   <= w2_val;
                    dsve_pkg::SEL_T1:   r_t1   <= w2_val;
                    dsve_pkg::SEL_RS:   r_rs   <= w2_val;
                    default:            ;
                endcase
            end
            if (w1_en) begin
                case (w1_sel)
                    dsve_pkg::SEL_G:    r_g    <= w1_val;
                    dsve_pkg::SEL_ACC:  r_acc  <= w1_val;
                    dsve_pkg::SEL_BASE: r_base <= w1_val;
                    dsve_pkg::SEL_EXP:  r_exp  <= w1_val;
                    dsve_pkg::SEL_R0:   r_r0   <= w1_val;
                    dsve_pkg::SEL_R1:   r_r1   <= w1_val;
                    dsve_pkg::SEL_C0:   r_c0   <= w1_val;
                    dsve_pkg::SEL_C1:   r_c1   <= w1_val;
                    dsve_pkg::SEL_QT:   r_qt   <= w1_val;
                    dsve_pkg::SEL_EX:   r_ex   <= w1_val;
                    dsve_pkg::SEL_T0:   r_t0   <= w1_val;
                    dsve_pkg::SEL_T1:   r_t1   <= w1_val;
                    dsve_pkg::SEL_RS:   r_rs   <= w1_val;
                    default:            ;
                endcase
            end
        end
    end

    assign o_stat = '{done: r_done, exp_zero: (r_exp == '0), exp_even: ~r_exp[0],
                      r1_zero: (r_r1 == '0), range_bad: w_range_bad, mode: r_mode};

    assign o_valid     = r_vld;
    assign o_value_a   = r_va;
    assign o_value_b   = r_vb;
    assign o_valid_res = r_ok;

endmodule

/* bench/tb.sv */
// Testbench for dsa_sign_verify_engine_core: random and directed DSA transactions
// checked against a behavioural predictor of key generation, signing and verification.
// Depends on dsve_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] x;
        logic [31:0] msg;
        logic [31:0] k;
        logic [31:0] y;
        logic [31:0] r;
        logic [31:0] s;
    } t_dsa_req;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic        ok;
    } t_dsa_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = dsve_pkg::CFG_PRIME_P;
    logic [31:0] i_cfg_data = '0;
    logic [1:0]  i_mode = dsve_pkg::MODE_PUBKEY;
    logic [31:0] i_private_key = '0;
    logic [31:0] i_message = '0;
    logic [31:0] i_nonce = '0;
    logic [31:0] i_public_key = '0;
    logic [31:0] i_sig_r = '0;
    logic [31:0] i_sig_s = '0;
    logic        o_valid;
    logic [31:0] o_value_a;
    logic [31:0] o_value_b;
    logic        o_valid_res;

    t_dsa_res expected_results[$];
    t_dsa_req pending_requests[$];
    t_dsa_req in_flight;
    logic [63:0] grp_p = 67;
    logic [63:0] grp_q = 11;
    logic [63:0] grp_h = 3;
    logic        hold_requests = 1'b1;
    int          gap_left = 0;
    int          fail_count = 0;
    int          results_seen = 0;
    int          valid_sigs = 0;
    int          idle_cycles = 0;

    dsa_sign_verify_engine_core u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] mod_red(logic [63:0] a, logic [63:0] m);
        return (m != 0) ? a % m : 64'd0;
    endfunction

    function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        if (m == 0) return 64'd0;
        return ((a % m) * (b % m)) % m;
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = mod_red(1, m);
        base = mod_red(base, m);
        while (e != 0) begin
            if (e[0]) acc = mod_mul(acc, base, m);
            base = mod_mul(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] mod_inv(logic [63:0] a, logic [63:0] m);
        logic [63:0] r0, r1, c0, c1, qt, t;
        if (m == 0) return 64'd0;
        r0 = a % m;
        r1 = m;
        c0 = mod_red(1, m);
        c1 = 0;
        while (r1 != 0) begin
            qt = r0 / r1;
            t = r0 - qt * r1;
            r0 = r1;
            r1 = t;
            t = mod_mul(qt, c1, m);
            t = (c0 >= t) ? c0 - t : c0 + (m - t);
            c0 = c1;
            c1 = t;
        end
        return c0;
    endfunction

    function automatic logic [63:0] group_generator();
        logic [31:0] pm1;
        pm1 = grp_p[31:0] - 32'd1;
        return mod_pow(grp_h, (grp_q != 0) ? {32'd0, pm1} / grp_q : 64'd0, grp_p);
    endfunction

    function automatic t_dsa_res predict_dsa(t_dsa_req rq);
        t_dsa_res    res;
        logic [63:0] g, r, t, w, v;
        res = '{a: '0, b: '0, ok: 1'b0};
        g = group_generator();
        case (rq.mode)
            dsve_pkg::MODE_PUBKEY: res.a = 32'(mod_pow(g, {32'd0, rq.x}, grp_p));
            dsve_pkg::MODE_SIGN: begin
                r = mod_red(mod_pow(g, {32'd0, rq.k}, grp_p), grp_q);
                t = mod_red(mod_red({32'd0, rq.msg}, grp_q) + mod_mul({32'd0, rq.x}, r, grp_q),
                            grp_q);
                res.a = 32'(r);
                res.b = 32'(mod_mul(mod_inv({32'd0, rq.k}, grp_q), t, grp_q));
            end
            dsve_pkg::MODE_VERIFY: begin
                if (rq.r >= 1 && rq.r < grp_q && rq.s >= 1 && rq.s < grp_q) begin
                    w = mod_inv({32'd0, rq.s}, grp_q);
                    v = mod_mul(mod_pow(g, mod_mul({32'd0, rq.msg}, w, grp_q), grp_p),
                                mod_pow({32'd0, rq.y}, mod_mul({32'd0, rq.r}, w, grp_q),
                                        grp_p), grp_p);
                    res.ok = (mod_red(v, grp_q) == {32'd0, rq.r});
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_dsa_req make_req(logic [1:0] mode, logic [31:0] x, logic [31:0] msg,
                                          logic [31:0] k, logic [31:0] y, logic [31:0] r,
                                          logic [31:0] s);
        t_dsa_req rq;
        rq = '{mode: mode, x: x, msg: msg, k: k, y: y, r: r, s: s};
        return rq;
    endfunction

    // A verify request built from a genuine signature, optionally damaged in one field.
    function automatic t_dsa_req signed_verify(logic damage);
        t_dsa_req rq, sg;
        t_dsa_res pk, sig;
        sg = make_req(dsve_pkg::MODE_SIGN, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
        pk = predict_dsa(make_req(dsve_pkg::MODE_PUBKEY, sg.x, 0, 0, 0, 0, 0));
        sig = predict_dsa(sg);
        rq = make_req(dsve_pkg::MODE_VERIFY, $urandom, sg.msg, $urandom, pk.a, sig.a, sig.b);
        if (damage) begin
            case ($urandom_range(2))
                0: rq.msg = rq.msg ^ (32'd1 << $urandom_range(31));
                1: rq.r = rq.r + 32'd1;
                default: rq.s = rq.s ^ (32'd1 << $urandom_range(4));
            endcase
        end
        return rq;
    endfunction

    function automatic t_dsa_req random_req();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return signed_verify(1'b0);
        if (pick < 40) return signed_verify(1'b1);
        return make_req(pick < 90 ? 2'($urandom_range(2)) : dsve_pkg::MODE_NONE, $urandom,
                        $urandom, $urandom, $urandom,
                        pick < 70 ? 32'($urandom_range(15)) : 32'($urandom),
                        pick < 80 ? 32'($urandom_range(15)) : 32'($urandom));
    endfunction

    task automatic wait_idle();
        while (pending_requests.size() != 0 || start || busy || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            dsve_pkg::CFG_PRIME_P: grp_p = {32'd0, val};
            dsve_pkg::CFG_PRIME_Q: grp_q = {32'd0, val};
            default:               grp_h = {32'd0, val};
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(logic [31:0] p, logic [31:0] q, logic [31:0] h, int count);
        wait_idle();
        hold_requests = 1'b1;
        write_cfg(dsve_pkg::CFG_PRIME_P, p);
        write_cfg(dsve_pkg::CFG_PRIME_Q, q);
        write_cfg(dsve_pkg::CFG_BASE_H, h);
        @(posedge i_clk);
        for (int i = 0; i < count; i++) pending_requests.push_back(random_req());
        hold_requests = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            expected_results.push_back(predict_dsa(in_flight));
            start <= 1'b0;
            gap_left <= ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (!hold_requests && pending_requests.size() != 0) begin
                in_flight = pending_requests.pop_front();
                i_mode <= in_flight.mode;
                i_private_key <= in_flight.x;
                i_message <= in_flight.msg;
                i_nonce <= in_flight.k;
                i_public_key <= in_flight.y;
                i_sig_r <= in_flight.r;
                i_sig_s <= in_flight.s;
                start <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_dsa_res exp_res;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with no transaction outstanding");
                fail_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (exp_res.ok) valid_sigs++;
                if (o_value_a !== exp_res.a) begin
                    $error("value_a: expected %h, got %h", exp_res.a, o_value_a);
                    fail_count++;
                end
                if (o_value_b !== exp_res.b) begin
                    $error("value_b: expected %h, got %h", exp_res.b, o_value_b);
                    fail_count++;
                end
                if (o_valid_res !== exp_res.ok) begin
                    $error("valid_res: expected %b, got %b", exp_res.ok, o_valid_res);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 300000) begin
            $display("watchdog expired with %0d results outstanding", expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        pending_requests.push_back(make_req(dsve_pkg::MODE_PUBKEY, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_req(dsve_pkg::MODE_PUBKEY, '1, '1, '1, '1, '1, '1));
        pending_requests.push_back(make_req(dsve_pkg::MODE_PUBKEY, 5, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_req(dsve_pkg::MODE_SIGN, 7, 9, 3, 0, 0, 0));
        pending_requests.push_back(make_req(dsve_pkg::MODE_SIGN, 7, 9, 0, 0, 0, 0));
        pending_requests.push_back(make_req(dsve_pkg::MODE_SIGN, 4, 2, 11, 0, 0, 0));
        pending_requests.push_back(make_req(dsve_pkg::MODE_SIGN, '1, '1, '1, 0, 0, 0));
        pending_requests.push_back(make_req(dsve_pkg::MODE_NONE, '1, '1, '1, '1, '1, '1));
        pending_requests.push_back(make_req(dsve_pkg::MODE_VERIFY, 0, 5, 0, 9, 0, 3));
        pending_requests.push_back(make_req(dsve_pkg::MODE_VERIFY, 0, 5, 0, 9, 3, 0));
        pending_requests.push_back(make_req(dsve_pkg::MODE_VERIFY, 0, 5, 0, 9, 11, 3));
        pending_requests.push_back(make_req(dsve_pkg::MODE_VERIFY, 0, 5, 0, 9, 3, 11));
        pending_requests.push_back(make_req(dsve_pkg::MODE_VERIFY, 0, 5, 0, 9, 10, 10));
        pending_requests.push_back(make_req(dsve_pkg::MODE_VERIFY, 0, 5, 0, 9, '1, '1));
        pending_requests.push_back(make_req(dsve_pkg::MODE_VERIFY, '1, '1, '1, '1, 1, 1));
        for (int i = 0; i < 5; i++) pending_requests.push_back(signed_verify(1'b0));
        hold_requests = 1'b0;
        run_phase(32'd23, 32'd11, 32'd2, 30);
        run_phase(32'hFFFFFFFB, 32'd22605091, 32'd7, 25);
        run_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 15);
        run_phase(32'd3, 32'd2, 32'd2, 15);
        run_phase(32'd7, 32'd0, 32'd5, 8);
        run_phase(32'd1019, 32'd509, 32'd5, 25);
        wait_idle();
        repeat (50) @(posedge i_clk);
        $display("Checked %0d results over seven group settings; %0d signatures verified.",
                 results_seen, valid_sigs);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/dsve_pkg.sv
rtl/dsve_ctrl.sv
rtl/dsve_datapath.sv
rtl/dsa_sign_verify_engine_core.sv
bench/tb.sv
